// File: design/windowed_two_opt_route_improver_core_assert.svh
// assertion macros used by the route improver controller
`ifndef WINDOWED_TWO_OPT_ROUTE_IMPROVER_CORE_ASSERT_SVH
`define WINDOWED_TWO_OPT_ROUTE_IMPROVER_CORE_ASSERT_SVH

`ifndef SYNTH
`define W2O_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("w2o assertion failed");
`define W2O_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("w2o assertion failed");
`else
`define W2O_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define W2O_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/w2o_pkg.sv
package w2o_pkg;

    localparam int MAX_NODES     = 64;
    localparam int MAX_ROUTE     = 64;
    localparam int DIST_BITS_DEF = 24;
    localparam int WINDOW_MIN    = 8;
    localparam int WINDOW_MAX    = 40;
    localparam int SMALL_ROUTE   = 16;
    localparam int WINDOW_DIV    = 40;
    localparam int MIN_LEN       = 4;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int POS_W    = $clog2(MAX_ROUTE);
    localparam int LEN_W    = POS_W + 1;
    localparam int IDF_W    = 6;
    localparam int DISTF_W  = 24;
    localparam int BUDGET_W = 20;
    localparam int PASS_W   = 4;
    localparam int CHECKS_W = BUDGET_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int CHECK_BUDGET_RST = 600000;
    localparam int MAX_PASSES_RST   = 4;

    // reciprocal for len / WINDOW_DIV, exact over the route length range
    localparam int WDIV_SHIFT = 13;
    localparam int WDIV_MUL   = (1 << WDIV_SHIFT) / WINDOW_DIV + 1;

    typedef enum logic [1:0] {
        REQ_DIST_WR  = 2'd0,
        REQ_ROUTE_WR = 2'd1,
        REQ_RUN      = 2'd2,
        REQ_ROUTE_RD = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RTD    = 2'd0,
        CFG_BUDGET = 2'd1,
        CFG_PASSES = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_DATA,
        S_RUN_INIT,
        S_PASS,
        S_ROW,
        S_ROW_A,
        S_ROW_B,
        S_ROW_C,
        S_CHECK,
        S_BD,
        S_AB,
        S_CD,
        S_EVAL,
        S_SW_RLO,
        S_SW_RHI,
        S_SW_WLO,
        S_SW_WHI,
        S_PASS_END,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic                rtd;
        logic [BUDGET_W-1:0] budget;
        logic [PASS_W-1:0]   max_passes;
    } cfg_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [POS_W-1:0] waddr;
        logic [POS_W-1:0] raddr;
        logic [IDF_W-1:0] wdata;
    } rt_port_t;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [2*NODE_W-1:0] waddr;
        logic [2*NODE_W-1:0] raddr;
    } dist_ctl_t;

    function automatic logic [LEN_W-1:0] window_for(input logic [LEN_W-1:0] len);
        logic [LEN_W+WDIV_SHIFT-1:0] prod;
        logic [LEN_W-1:0]            q;
        logic [LEN_W-1:0]            w;
        prod = (LEN_W+WDIV_SHIFT)'(len) * (LEN_W+WDIV_SHIFT)'(WDIV_MUL);
        q    = LEN_W'(prod >> WDIV_SHIFT);
        if (len <= LEN_W'(SMALL_ROUTE)) begin
            w = len;
        end else if (q < LEN_W'(WINDOW_MIN)) begin
            w = LEN_W'(WINDOW_MIN);
        end else if (q > LEN_W'(WINDOW_MAX)) begin
            w = LEN_W'(WINDOW_MAX);
        end else begin
            w = q;
        end
        return w;
    endfunction

endpackage

// File: design/w2o_route_mem.sv
module w2o_route_mem
    import w2o_pkg::*;
(
    input  logic             aclk,
    input  rt_port_t         port,
    output logic [IDF_W-1:0] rdata
);

    logic [IDF_W-1:0] mem [MAX_ROUTE];
    logic [IDF_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (port.we) begin
            mem[port.waddr] <= port.wdata;
        end
        if (port.re) begin
            rdata_reg <= mem[port.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/w2o_dist_mem.sv
module w2o_dist_mem
    import w2o_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  logic                 aclk,
    input  dist_ctl_t            ctl,
    input  logic [DIST_BITS-1:0] wdata,
    output logic [DIST_BITS-1:0] rdata
);

    localparam int DEPTH = MAX_NODES * MAX_NODES;

    logic [DIST_BITS-1:0] mem [DEPTH];
    logic [DIST_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= wdata;
        end
        if (ctl.re) begin
            rdata_reg <= mem[ctl.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/w2o_ctrl.sv
`include "windowed_two_opt_route_improver_core_assert.svh"

module w2o_ctrl
    import w2o_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [5:0]           s_from_node,
    input  logic [5:0]           s_to_node,
    input  logic [DISTF_W-1:0]   s_distance,
    input  logic [5:0]           s_route_pos,
    input  logic [IDF_W-1:0]     s_node_id,
    input  logic [6:0]           s_route_len,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDF_W-1:0]     m_read_node,
    output logic                 m_improved,
    output logic [PASS_W-1:0]    m_passes_improved,
    output logic [CHECKS_W-1:0]  m_checks_used,
    output logic                 m_budget_hit,
    output rt_port_t             rt_port,
    input  logic [IDF_W-1:0]     rt_rdata,
    output dist_ctl_t            dist_ctl,
    output logic [DIST_BITS-1:0] dist_wdata,
    input  logic [DIST_BITS-1:0] dist_rdata
);

    localparam int ACC_W = DIST_BITS + 2;

    ctrl_state_t state_reg, state_next;

    logic [LEN_W-1:0]        len_reg, len_next;
    logic [LEN_W-1:0]        last_reg, last_next;
    logic [LEN_W-1:0]        win_reg, win_next;
    logic [LEN_W-1:0]        i_reg, i_next;
    logic [LEN_W-1:0]        k_reg, k_next;
    logic [LEN_W-1:0]        klim_reg, klim_next;
    logic [POS_W-1:0]        lo_reg, lo_next;
    logic [POS_W-1:0]        hi_reg, hi_next;
    logic [IDF_W-1:0]        a_reg, a_next;
    logic [IDF_W-1:0]        b_reg, b_next;
    logic [IDF_W-1:0]        c_reg, c_next;
    logic [IDF_W-1:0]        d_reg, d_next;
    logic [IDF_W-1:0]        tmp_reg, tmp_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [CHECKS_W-1:0]     checks_reg, checks_next;
    logic [PASS_W-1:0]       passes_reg, passes_next;
    logic                    hit_reg, hit_next;
    logic [IDF_W-1:0]        node_reg, node_next;

    logic                    m_valid_reg, m_valid_next;
    logic [IDF_W-1:0]        m_node_reg, m_node_next;
    logic                    m_impr_reg, m_impr_next;
    logic [PASS_W-1:0]       m_passes_reg, m_passes_next;
    logic [CHECKS_W-1:0]     m_checks_reg, m_checks_next;
    logic                    m_hit_reg, m_hit_next;

    logic                    in_acc;
    logic                    pos_ok;
    logic [LEN_W-1:0]        len_sat;
    logic [LEN_W-1:0]        i_plus, k_plus, i_minus, last_m1, klim_new;
    logic [LEN_W:0]          win_sum;
    logic                    row_end, has_d, k_adv, over_budget, pass_more, short_run;
    logic                    out_free;
    logic [CHECKS_W-1:0]     checks_inc;
    logic signed [ACC_W-1:0] dist_ext, delta;

    assign in_acc   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign pos_ok   = (s_route_pos < MAX_ROUTE);
    assign len_sat  = (s_route_len > LEN_W'(MAX_ROUTE)) ? LEN_W'(MAX_ROUTE) : s_route_len;

    assign i_plus   = i_reg + LEN_W'(1);
    assign i_minus  = i_reg - LEN_W'(1);
    assign k_plus   = k_reg + LEN_W'(1);
    assign last_m1  = last_reg - LEN_W'(1);
    assign win_sum  = {1'b0, i_reg} + {1'b0, win_reg};
    assign klim_new = (win_sum > {1'b0, last_m1}) ? last_m1 : win_sum[LEN_W-1:0];
    assign row_end  = (i_plus >= last_reg);
    assign has_d    = (k_plus < len_reg);
    assign k_adv    = (k_plus <= klim_reg);

    assign checks_inc  = checks_reg + CHECKS_W'(1);
    assign over_budget = (checks_inc > {1'b0, cfg.budget});
    assign pass_more   = (({1'b0, passes_reg} + (PASS_W+1)'(1)) < {1'b0, cfg.max_passes});
    assign short_run   = (len_reg < LEN_W'(MIN_LEN)) || (cfg.max_passes == '0);

    assign dist_ext = $signed({2'b00, dist_rdata});
    assign delta    = acc_reg - dist_ext;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    case (s_req_type)
                        REQ_RUN:      state_next = S_RUN_INIT;
                        REQ_ROUTE_RD: state_next = pos_ok ? S_RD_DATA : S_DONE;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_RD_DATA:  state_next = S_DONE;
            S_RUN_INIT: state_next = short_run ? S_DONE : S_PASS;
            S_PASS:     state_next = S_ROW;
            S_ROW:      state_next = row_end ? S_DONE : S_ROW_A;
            S_ROW_A:    state_next = S_ROW_B;
            S_ROW_B:    state_next = S_ROW_C;
            S_ROW_C:    state_next = S_CHECK;
            S_CHECK: begin
                if (over_budget) begin
                    state_next = S_DONE;
                end else if (has_d) begin
                    state_next = S_BD;
                end else if (cfg.rtd) begin
                    state_next = k_adv ? S_CHECK : S_ROW;
                end else begin
                    state_next = S_AB;
                end
            end
            S_BD:       state_next = S_AB;
            S_AB:       state_next = has_d ? S_CD : S_EVAL;
            S_CD:       state_next = S_EVAL;
            S_EVAL: begin
                if (delta < 0) begin
                    state_next = S_SW_RLO;
                end else begin
                    state_next = k_adv ? S_CHECK : S_ROW;
                end
            end
            S_SW_RLO:   state_next = (lo_reg < hi_reg) ? S_SW_RHI : S_PASS_END;
            S_SW_RHI:   state_next = S_SW_WLO;
            S_SW_WLO:   state_next = S_SW_WHI;
            S_SW_WHI:   state_next = S_SW_RLO;
            S_PASS_END: state_next = pass_more ? S_PASS : S_DONE;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        len_next    = len_reg;
        last_next   = last_reg;
        win_next    = win_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        klim_next   = klim_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        tmp_next    = tmp_reg;
        acc_next    = acc_reg;
        checks_next = checks_reg;
        passes_next = passes_reg;
        hit_next    = hit_reg;
        node_next   = node_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_node_next   = m_node_reg;
        m_impr_next   = m_impr_reg;
        m_passes_next = m_passes_reg;
        m_checks_next = m_checks_reg;
        m_hit_next    = m_hit_reg;

        rt_port       = '0;
        dist_ctl      = '0;
        dist_wdata    = DIST_BITS'(s_distance);
        dist_ctl.waddr = {s_from_node[NODE_W-1:0], s_to_node[NODE_W-1:0]};
        rt_port.waddr  = s_route_pos[POS_W-1:0];
        rt_port.wdata  = s_node_id;
        rt_port.raddr  = s_route_pos[POS_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    checks_next = '0;
                    passes_next = '0;
                    hit_next    = 1'b0;
                    node_next   = '0;
                    len_next    = len_sat;
                    case (s_req_type)
                        REQ_DIST_WR:  dist_ctl.we = 1'b1;
                        REQ_ROUTE_WR: rt_port.we = pos_ok;
                        REQ_ROUTE_RD: rt_port.re = pos_ok;
                        default: ;
                    endcase
                end
            end
            S_RD_DATA: node_next = rt_rdata;
            S_RUN_INIT: begin
                last_next = cfg.rtd ? (len_reg - LEN_W'(1)) : len_reg;
                win_next  = window_for(len_reg);
            end
            S_PASS: i_next = LEN_W'(1);
            S_ROW: begin
                klim_next     = klim_new;
                k_next        = i_plus;
                rt_port.re    = !row_end;
                rt_port.raddr = i_minus[POS_W-1:0];
            end
            S_ROW_A: begin
                a_next        = rt_rdata;
                rt_port.re    = 1'b1;
                rt_port.raddr = i_reg[POS_W-1:0];
            end
            S_ROW_B: begin
                b_next        = rt_rdata;
                rt_port.re    = 1'b1;
                rt_port.raddr = k_reg[POS_W-1:0];
            end
            S_ROW_C: c_next = rt_rdata;
            S_CHECK: begin
                checks_next    = checks_inc;
                acc_next       = '0;
                dist_ctl.raddr = {a_reg[NODE_W-1:0], c_reg[NODE_W-1:0]};
                rt_port.raddr  = k_plus[POS_W-1:0];
                if (over_budget) begin
                    hit_next = 1'b1;
                end else if (has_d) begin
                    rt_port.re  = 1'b1;
                    dist_ctl.re = 1'b1;
                end else if (cfg.rtd) begin
                    // depot tail: nothing to evaluate, move on
                    if (k_adv) begin
                        k_next = k_plus;
                        c_next = d_reg;
                    end else begin
                        i_next = i_plus;
                    end
                end else begin
                    dist_ctl.re = 1'b1;
                end
            end
            S_BD: begin
                d_next         = rt_rdata;
                acc_next       = acc_reg + dist_ext;
                dist_ctl.re    = 1'b1;
                dist_ctl.raddr = {b_reg[NODE_W-1:0], rt_rdata[NODE_W-1:0]};
            end
            S_AB: begin
                acc_next       = acc_reg + dist_ext;
                dist_ctl.re    = 1'b1;
                dist_ctl.raddr = {a_reg[NODE_W-1:0], b_reg[NODE_W-1:0]};
            end
            S_CD: begin
                acc_next       = acc_reg - dist_ext;
                dist_ctl.re    = 1'b1;
                dist_ctl.raddr = {c_reg[NODE_W-1:0], d_reg[NODE_W-1:0]};
            end
            S_EVAL: begin
                if (delta < 0) begin
                    lo_next = i_reg[POS_W-1:0];
                    hi_next = k_reg[POS_W-1:0];
                end else if (k_adv) begin
                    k_next = k_plus;
                    c_next = d_reg;
                end else begin
                    i_next = i_plus;
                end
            end
            S_SW_RLO: begin
                rt_port.re    = (lo_reg < hi_reg);
                rt_port.raddr = lo_reg;
            end
            S_SW_RHI: begin
                tmp_next      = rt_rdata;
                rt_port.re    = 1'b1;
                rt_port.raddr = hi_reg;
            end
            S_SW_WLO: begin
                rt_port.we    = 1'b1;
                rt_port.waddr = lo_reg;
                rt_port.wdata = rt_rdata;
            end
            S_SW_WHI: begin
                rt_port.we    = 1'b1;
                rt_port.waddr = hi_reg;
                rt_port.wdata = tmp_reg;
                lo_next       = lo_reg + POS_W'(1);
                hi_next       = hi_reg - POS_W'(1);
            end
            S_PASS_END: passes_next = passes_reg + PASS_W'(1);
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_node_next   = node_reg;
                    m_impr_next   = (passes_reg != '0);
                    m_passes_next = passes_reg;
                    m_checks_next = checks_reg;
                    m_hit_next    = hit_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            checks_reg  <= '0;
            passes_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            checks_reg  <= checks_next;
            passes_reg  <= passes_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg      <= len_next;
        last_reg     <= last_next;
        win_reg      <= win_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        klim_reg     <= klim_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        tmp_reg      <= tmp_next;
        acc_reg      <= acc_next;
        hit_reg      <= hit_next;
        node_reg     <= node_next;
        m_node_reg   <= m_node_next;
        m_impr_reg   <= m_impr_next;
        m_passes_reg <= m_passes_next;
        m_checks_reg <= m_checks_next;
        m_hit_reg    <= m_hit_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_read_node       = m_node_reg;
    assign m_improved        = m_impr_reg;
    assign m_passes_improved = m_passes_reg;
    assign m_checks_used     = m_checks_reg;
    assign m_budget_hit      = m_hit_reg;

    // a check that went on to the distance reads stayed within budget
    `W2O_ASSERT_IMP(a_budget_ok, aclk, aresetn, state_reg == S_BD,
        checks_reg <= {1'b0, cfg.budget})
    // reversal swaps only while the ends have not crossed
    `W2O_ASSERT_IMP(a_swap_order, aclk, aresetn, state_reg == S_SW_RHI, lo_reg < hi_reg)
    `W2O_ASSERT_IMP(a_k_range, aclk, aresetn, state_reg == S_CHECK,
        (k_reg > i_reg) && (k_reg <= klim_reg))
    // one item at a time
    `W2O_ASSERT_NXT(a_one_item, aclk, aresetn, in_acc, !s_ready)
    // a finished result never overwrites one still waiting
    `W2O_ASSERT_NXT(a_no_overwrite, aclk, aresetn,
        (state_reg == S_DONE) && m_valid_reg && !m_ready, state_reg == S_DONE)

endmodule

// File: design/windowed_two_opt_route_improver_core.sv
// a run steps S_CHECK, S_BD, S_AB, S_CD and S_EVAL per move check, S_CHECK, S_AB and
// S_EVAL at the open tail (one route read overlapped with reads through the single distance
// memory read port), S_ROW to S_ROW_C per row start, S_SW_RLO to S_SW_WHI per swapped pair
// one item at a time; the next item is taken once the result sits in the output register
// reset: synchronous active-low, config returns to depot 1, budget 600000, passes 4;
// memory contents are undefined until written and get no clearing pass
module windowed_two_opt_route_improver_core
    import w2o_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [5:0]            s_from_node,
    input  logic [5:0]            s_to_node,
    input  logic [DISTF_W-1:0]    s_distance,
    input  logic [5:0]            s_route_pos,
    input  logic [IDF_W-1:0]      s_node_id,
    input  logic [6:0]            s_route_len,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IDF_W-1:0]      m_read_node,
    output logic                  m_improved,
    output logic [PASS_W-1:0]     m_passes_improved,
    output logic [CHECKS_W-1:0]   m_checks_used,
    output logic                  m_budget_hit
);

    logic                rtd_reg, rtd_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [PASS_W-1:0]   passes_reg, passes_next;
    cfg_t                cfg;

    rt_port_t             rt_port;
    logic [IDF_W-1:0]     rt_rdata;
    dist_ctl_t            dist_ctl;
    logic [DIST_BITS-1:0] dist_wdata;
    logic [DIST_BITS-1:0] dist_rdata;

    always_comb begin
        rtd_next    = rtd_reg;
        budget_next = budget_reg;
        passes_next = passes_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_RTD:    rtd_next = cfg_wdata[0];
                CFG_BUDGET: budget_next = cfg_wdata[BUDGET_W-1:0];
                CFG_PASSES: passes_next = cfg_wdata[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtd_reg    <= 1'b1;
            budget_reg <= BUDGET_W'(CHECK_BUDGET_RST);
            passes_reg <= PASS_W'(MAX_PASSES_RST);
        end else begin
            rtd_reg    <= rtd_next;
            budget_reg <= budget_next;
            passes_reg <= passes_next;
        end
    end

    assign cfg.rtd        = rtd_reg;
    assign cfg.budget     = budget_reg;
    assign cfg.max_passes = passes_reg;

    w2o_route_mem u_route_mem (
        .aclk  (aclk),
        .port  (rt_port),
        .rdata (rt_rdata)
    );

    w2o_dist_mem #(
        .DIST_BITS (DIST_BITS)
    ) u_dist_mem (
        .aclk  (aclk),
        .ctl   (dist_ctl),
        .wdata (dist_wdata),
        .rdata (dist_rdata)
    );

    w2o_ctrl #(
        .DIST_BITS (DIST_BITS)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_from_node       (s_from_node),
        .s_to_node         (s_to_node),
        .s_distance        (s_distance),
        .s_route_pos       (s_route_pos),
        .s_node_id         (s_node_id),
        .s_route_len       (s_route_len),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_node       (m_read_node),
        .m_improved        (m_improved),
        .m_passes_improved (m_passes_improved),
        .m_checks_used     (m_checks_used),
        .m_budget_hit      (m_budget_hit),
        .rt_port           (rt_port),
        .rt_rdata          (rt_rdata),
        .dist_ctl          (dist_ctl),
        .dist_wdata        (dist_wdata),
        .dist_rdata        (dist_rdata)
    );

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import w2o_pkg::*;

    localparam int ITEMS    = 1950;
    localparam int N_PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        req_t               req;
        logic [5:0]         from_n;
        logic [5:0]         to_n;
        logic [DISTF_W-1:0] cost;
        logic [5:0]         pos;
        logic [IDF_W-1:0]   node;
        logic [6:0]         len;
    } route_req_t;

    typedef struct packed {
        logic [IDF_W-1:0]    read_node;
        logic                improved;
        logic [PASS_W-1:0]   passes;
        logic [CHECKS_W-1:0] checks;
        logic                hit;
    } route_res_t;

    typedef struct packed {
        route_req_t it;
        logic       known;
        route_res_t res;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type = '0;
    logic [5:0]            s_from_node = '0;
    logic [5:0]            s_to_node = '0;
    logic [DISTF_W-1:0]    s_distance = '0;
    logic [5:0]            s_route_pos = '0;
    logic [IDF_W-1:0]      s_node_id = '0;
    logic [6:0]            s_route_len = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [IDF_W-1:0]      m_read_node;
    logic                  m_improved;
    logic [PASS_W-1:0]     m_passes_improved;
    logic [CHECKS_W-1:0]   m_checks_used;
    logic                  m_budget_hit;

    windowed_two_opt_route_improver_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_from_node       (s_from_node),
        .s_to_node         (s_to_node),
        .s_distance        (s_distance),
        .s_route_pos       (s_route_pos),
        .s_node_id         (s_node_id),
        .s_route_len       (s_route_len),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_node       (m_read_node),
        .m_improved        (m_improved),
        .m_passes_improved (m_passes_improved),
        .m_checks_used     (m_checks_used),
        .m_budget_hit      (m_budget_hit)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    bit [DISTF_W-1:0] dist_mem [0:MAX_NODES*MAX_NODES-1];
    bit               dist_ok  [0:MAX_NODES*MAX_NODES-1];
    bit [IDF_W-1:0]   route_mem [0:MAX_ROUTE-1];
    bit               route_ok  [0:MAX_ROUTE-1];
    bit               rtd_cfg = 1'b1;
    int               budget_cfg = CHECK_BUDGET_RST;
    int               passes_cfg = MAX_PASSES_RST;
    int               check_cnt;

    route_res_t pending_outcomes [$];
    dir_row_t   directed_rows [$];
    route_res_t want;
    int         err_cnt = 0;
    int         n_res = 0;
    int         n_sent = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;

    function automatic longint edge_cost(input bit [5:0] x, input bit [5:0] y);
        return longint'(dist_mem[{x, y}]);
    endfunction

    function automatic int scan_window(input int n);
        int w;
        if (n <= SMALL_ROUTE) return n;
        w = n / WINDOW_DIV;
        if (w < WINDOW_MIN) w = WINDOW_MIN;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        return w;
    endfunction

    // 1 reversal made, 0 nothing improving, -1 budget exceeded
    function automatic int two_opt_pass(input int n, input int win);
        int         last, i, k, klim, lo, hi, res;
        bit         done, eval;
        longint     delta;
        bit [5:0]   a, b, c, d, t;
        last = rtd_cfg ? n - 1 : n;
        res  = 0;
        done = 1'b0;
        i    = 1;
        while (!done && i + 1 < last) begin
            klim = i + win;
            if (klim > last - 1) klim = last - 1;
            k = i + 1;
            while (!done && k <= klim) begin
                check_cnt++;
                if (check_cnt > budget_cfg) begin
                    res  = -1;
                    done = 1'b1;
                end else begin
                    a     = route_mem[i-1];
                    b     = route_mem[i];
                    c     = route_mem[k];
                    eval  = 1'b1;
                    delta = 0;
                    if (k + 1 < n) begin
                        d = route_mem[k+1];
                        delta = (edge_cost(a, c) + edge_cost(b, d)) -
                                (edge_cost(a, b) + edge_cost(c, d));
                    end else if (rtd_cfg) begin
                        eval = 1'b0;
                    end else begin
                        // open tail: only the edge into the segment changes
                        delta = edge_cost(a, c) - edge_cost(a, b);
                    end
                    if (eval && delta < 0) begin
                        lo = i;
                        hi = k;
                        while (lo < hi) begin
                            t = route_mem[lo];
                            route_mem[lo] = route_mem[hi];
                            route_mem[hi] = t;
                            lo++;
                            hi--;
                        end
                        res  = 1;
                        done = 1'b1;
                    end
                end
                k++;
            end
            i++;
        end
        return res;
    endfunction

    function automatic route_res_t route_outcome(input route_req_t it);
        route_res_t r;
        int         n, win, p, ok_passes, res;
        bit         stop;
        r = '0;
        case (it.req)
            REQ_DIST_WR: begin
                dist_mem[{it.from_n, it.to_n}] = it.cost;
                dist_ok[{it.from_n, it.to_n}]  = 1'b1;
            end
            REQ_ROUTE_WR: begin
                route_mem[it.pos] = it.node;
                route_ok[it.pos]  = 1'b1;
            end
            REQ_ROUTE_RD: r.read_node = route_mem[it.pos];
            REQ_RUN: begin
                n = (it.len > MAX_ROUTE) ? MAX_ROUTE : int'(it.len);
                check_cnt = 0;
                ok_passes = 0;
                if (n >= MIN_LEN) begin
                    win  = scan_window(n);
                    p    = 0;
                    stop = 1'b0;
                    while (!stop && p < passes_cfg) begin
                        res = two_opt_pass(n, win);
                        if (res < 0) begin
                            r.hit = 1'b1;
                            stop  = 1'b1;
                        end else if (res == 0) begin
                            stop = 1'b1;
                        end else begin
                            ok_passes++;
                        end
                        p++;
                    end
                end
                r.improved = (ok_passes != 0);
                r.passes   = ok_passes[PASS_W-1:0];
                r.checks   = check_cnt[CHECKS_W-1:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", n_res, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [CHECKS_W-1:0] got,
                               input logic [CHECKS_W-1:0] exp_v);
        if (got !== exp_v)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_v));
    endtask

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no item waiting");
            end else begin
                want = pending_outcomes.pop_front();
                check_field("read_node", m_read_node, want.read_node);
                check_field("improved", m_improved, want.improved);
                check_field("passes_improved", m_passes_improved, want.passes);
                check_field("checks_used", m_checks_used, want.checks);
                check_field("budget_hit", m_budget_hit, want.hit);
            end
            n_res++;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input route_req_t it, input bit known, input route_res_t kres);
        route_res_t pred;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= it.req;
        s_from_node <= it.from_n;
        s_to_node   <= it.to_n;
        s_distance  <= it.cost;
        s_route_pos <= it.pos;
        s_node_id   <= it.node;
        s_route_len <= it.len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = route_outcome(it);
        pending_outcomes.push_back(known ? kres : pred);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] keep, wd;
        case (idx)
            CFG_RTD:    keep = 20'h1;
            CFG_PASSES: keep = 20'hF;
            default:    keep = '1;
        endcase
        // bits above the register width carry noise
        wd = (value & keep) | (CFG_DATA_W'($urandom) & ~keep);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= wd;
        case (idx)
            CFG_RTD:    rtd_cfg = wd[0];
            CFG_BUDGET: budget_cfg = int'(wd);
            CFG_PASSES: passes_cfg = int'(wd[PASS_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic route_req_t rand_req(input req_t req);
        route_req_t it;
        it.req    = req;
        it.from_n = 6'($urandom);
        it.to_n   = 6'($urandom);
        it.cost   = DISTF_W'($urandom);
        it.pos    = 6'($urandom);
        it.node   = IDF_W'($urandom);
        it.len    = 7'($urandom);
        return it;
    endfunction

    function automatic logic [DISTF_W-1:0] rand_dist();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return DISTF_W'($urandom_range(255));
            default: return DISTF_W'($urandom);
        endcase
    endfunction

    task automatic send_dist(input logic [5:0] f, input logic [5:0] t,
                             input logic [DISTF_W-1:0] v);
        route_req_t it;
        it = rand_req(REQ_DIST_WR);
        it.from_n = f;
        it.to_n   = t;
        it.cost   = v;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_route_node(input logic [5:0] p, input logic [IDF_W-1:0] nd);
        route_req_t it;
        it = rand_req(REQ_ROUTE_WR);
        it.pos  = p;
        it.node = nd;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_read(input logic [5:0] p);
        route_req_t it;
        it = rand_req(REQ_ROUTE_RD);
        it.pos = p;
        send_item(it, 1'b0, '0);
    endtask

    // fills any route slot and edge cost the run could touch, then starts it
    task automatic run_route(input logic [6:0] len_f);
        int         n, p, q;
        route_req_t it;
        n = (len_f > MAX_ROUTE) ? MAX_ROUTE : int'(len_f);
        if (n >= MIN_LEN) begin
            for (p = 0; p < n; p++)
                if (!route_ok[p]) send_route_node(6'(p), IDF_W'($urandom));
            for (p = 0; p < n; p++)
                for (q = 0; q < n; q++)
                    if (!dist_ok[{route_mem[p], route_mem[q]}])
                        send_dist(route_mem[p], route_mem[q], rand_dist());
        end
        it = rand_req(REQ_RUN);
        it.len = len_f;
        send_item(it, 1'b0, '0);
    endtask

    task automatic noise_item();
        int p;
        case ($urandom_range(4))
            0: send_dist(6'($urandom), 6'($urandom), rand_dist());
            1: send_route_node(6'($urandom), IDF_W'($urandom));
            2: begin
                p = $urandom_range(MAX_ROUTE - 1);
                while (!route_ok[p]) p = (p + 1) % MAX_ROUTE;
                send_read(6'(p));
            end
            3: run_route(7'($urandom_range(MIN_LEN - 1)));
            default: run_route(7'($urandom_range(MIN_LEN, 8)));
        endcase
    endtask

    // a route built from a few nodes, its edge costs, one or two runs and some read-back
    task automatic route_seq();
        int         n_eff, len_f, psize, p, q;
        logic [5:0] pool [0:5];
        if ($urandom_range(99) < 5) begin
            n_eff = MAX_ROUTE;
            len_f = $urandom_range(MAX_ROUTE + 1, 127);
            psize = $urandom_range(2, 3);
        end else if ($urandom_range(99) < 15) begin
            n_eff = $urandom_range(SMALL_ROUTE + 1, MAX_ROUTE);
            len_f = n_eff;
            psize = $urandom_range(2, 4);
        end else begin
            n_eff = $urandom_range(MIN_LEN, SMALL_ROUTE);
            len_f = n_eff;
            psize = $urandom_range(2, 6);
        end
        for (p = 0; p < psize; p++) pool[p] = 6'($urandom);
        for (p = 0; p < psize; p++)
            for (q = 0; q < psize; q++)
                if (!dist_ok[{pool[p], pool[q]}] || $urandom_range(3) == 0)
                    send_dist(pool[p], pool[q], rand_dist());
        for (p = 0; p < n_eff; p++) begin
            send_route_node(6'(p), pool[$urandom_range(psize - 1)]);
            if ($urandom_range(99) < 3) noise_item();
        end
        run_route(7'(len_f));
        repeat ($urandom_range(1, 3)) send_read(6'($urandom_range(n_eff - 1)));
        if ($urandom_range(2) == 0) begin
            run_route(7'($urandom_range(MIN_LEN, n_eff)));
            send_read(6'($urandom_range(n_eff - 1)));
        end
    endtask

    task automatic add_row(input req_t req, input logic [5:0] f, input logic [5:0] t,
                           input logic [DISTF_W-1:0] dv, input logic [5:0] p,
                           input logic [IDF_W-1:0] nd, input logic [6:0] ln,
                           input bit known, input logic [IDF_W-1:0] rd);
        dir_row_t row;
        row.it.req    = req;
        row.it.from_n = f;
        row.it.to_n   = t;
        row.it.cost   = dv;
        row.it.pos    = p;
        row.it.node   = nd;
        row.it.len    = ln;
        row.known     = known;
        row.res       = '0;
        row.res.read_node = rd;
        directed_rows.push_back(row);
    endtask

    task automatic set_phase_cfg(input int ph);
        case (ph)
            1: begin
                write_cfg(CFG_RTD, 20'd0);
                write_cfg(CFG_BUDGET, 20'hFFFFF);
                write_cfg(CFG_PASSES, 20'd15);
            end
            2: begin
                // every check is over budget
                write_cfg(CFG_RTD, 20'd1);
                write_cfg(CFG_BUDGET, 20'd0);
                write_cfg(CFG_PASSES, 20'd1);
            end
            3: begin
                write_cfg(CFG_RTD, 20'd0);
                write_cfg(CFG_BUDGET, 20'($urandom_range(1, 400)));
                write_cfg(CFG_PASSES, 20'($urandom_range(1, 15)));
                write_cfg(CFG_UNUSED, 20'($urandom));
            end
            4: begin
                // no pass at all
                write_cfg(CFG_RTD, 20'd1);
                write_cfg(CFG_BUDGET, 20'($urandom_range(100000, 20'hFFFFF)));
                write_cfg(CFG_PASSES, 20'd0);
            end
            5: begin
                write_cfg(CFG_RTD, 20'($urandom_range(1)));
                write_cfg(CFG_BUDGET, 20'($urandom_range(20, 2000)));
                write_cfg(CFG_PASSES, 20'd15);
            end
            6: begin
                write_cfg(CFG_RTD, 20'd0);
                write_cfg(CFG_BUDGET, 20'd1);
                write_cfg(CFG_PASSES, 20'($urandom_range(15)));
            end
            default: begin
                write_cfg(CFG_RTD, 20'd1);
                write_cfg(CFG_BUDGET, 20'($urandom));
                write_cfg(CFG_PASSES, 20'd15);
            end
        endcase
    endtask

    initial begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int       ph, target, n_dir;
        dir_row_t row;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes, every request, short and zero-length runs under reset settings
        add_row(REQ_DIST_WR,  0,  0, 24'h000000, 63, 63, 127, 1, 0);
        add_row(REQ_DIST_WR, 63, 63, 24'hFFFFFF,  0,  0,   0, 1, 0);
        add_row(REQ_DIST_WR,  0, 63, 24'h000100, 21, 42,  85, 1, 0);
        add_row(REQ_DIST_WR, 63,  0, 24'h000001, 42, 21,  42, 1, 0);
        add_row(REQ_ROUTE_WR, 63, 63, 24'hFFFFFF,  0,  0, 127, 1, 0);
        add_row(REQ_ROUTE_WR,  0,  0, 24'h000000, 63, 63,   0, 1, 0);
        add_row(REQ_ROUTE_RD, 63, 63, 24'hFFFFFF, 63,  0, 127, 1, 63);
        add_row(REQ_ROUTE_WR,  5,  9, 24'h123456,  1, 63,   9, 1, 0);
        add_row(REQ_ROUTE_WR,  9,  5, 24'h654321,  2,  0,  17, 1, 0);
        add_row(REQ_ROUTE_WR,  1,  2, 24'hABCDEF,  3, 63,  33, 1, 0);
        add_row(REQ_ROUTE_RD,  0,  0, 24'h000000,  0, 63,   0, 1, 0);
        add_row(REQ_RUN,      63, 63, 24'hFFFFFF, 63, 63,   0, 1, 0);
        add_row(REQ_RUN,       0,  0, 24'h000000,  0,  0,   3, 1, 0);
        add_row(REQ_RUN,       0,  0, 24'h000000,  0,  0,   4, 0, 0);
        add_row(REQ_ROUTE_RD,  0,  0, 24'h000000,  1,  0,   0, 0, 0);
        add_row(REQ_ROUTE_RD,  0,  0, 24'h000000,  2,  0,   0, 0, 0);
        add_row(REQ_ROUTE_WR,  0,  0, 24'h000000,  4,  0,   0, 1, 0);
        add_row(REQ_ROUTE_WR,  0,  0, 24'h000000,  5, 63,   0, 1, 0);
        add_row(REQ_RUN,      63,  0, 24'hFFFFFF, 63,  0,   6, 0, 0);
        add_row(REQ_ROUTE_RD,  0,  0, 24'h000000,  3,  0,   0, 0, 0);
        add_row(REQ_ROUTE_RD,  0,  0, 24'h000000,  4,  0,   0, 0, 0);

        while (directed_rows.size() != 0) begin
            row = directed_rows.pop_front();
            send_item(row.it, row.known, row.res);
        end
        n_dir = n_sent;

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            if (ph != 0) set_phase_cfg(ph);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 83; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 83; end
                default: begin gap_pct = 15; stall_pct = 15; end
            endcase
            target = n_dir + (ph + 1) * ITEMS / N_PHASES;
            while (n_sent < target) begin
                if ($urandom_range(99) < 75) route_seq();
                else repeat ($urandom_range(1, 6)) noise_item();
                // hold off until the block has returned everything
                if ($urandom_range(99) < 8) drain_results();
            end
        end

        drain_results();
        repeat (50) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
